@@ rtl/lmdps_pkg.sv @@
// Shared types, codes and the dither threshold table for the LED matrix scanner.
package lmdps_pkg;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  localparam int unsigned STEP_W      = 6;
  localparam int unsigned TABLE_LEN   = 41;
  localparam int unsigned IN_DATA_W   = 16;
  localparam int unsigned OUT_DATA_W  = 16;
  localparam int unsigned COL_IDX_W   = 3;
  localparam int unsigned PATTERN_W   = 7;
  localparam int unsigned PIX_LEVEL_W = 6;

  localparam logic [STEP_W-1:0] STEP_LIMIT_RESET = 6'd40;

  localparam logic [STEP_W-1:0] DITHER_TABLE [TABLE_LEN] = '{
    6'd0,  6'd20, 6'd12, 6'd32, 6'd6,  6'd26, 6'd23, 6'd36, 6'd3,  6'd16,
    6'd29, 6'd9,  6'd24, 6'd4,  6'd34, 6'd14, 6'd40, 6'd21, 6'd1,  6'd37,
    6'd7,  6'd11, 6'd31, 6'd7,  6'd27, 6'd35, 6'd15, 6'd25, 6'd5,  6'd30,
    6'd10, 6'd22, 6'd39, 6'd2,  6'd19, 6'd33, 6'd13, 6'd28, 6'd8,  6'd18,
    6'd38
  };

  typedef struct packed {
    logic                   en;
    logic [2:0]             row;
    logic [2:0]             col;
    logic [PIX_LEVEL_W-1:0] level;
  } pix_wr_t;

endpackage

@@ rtl/lmdps_frame.sv @@
// Frame store of pixel levels and the dithered compare for one column.
module lmdps_frame #(
  parameter int unsigned ROWS       = 7,
  parameter int unsigned COLUMNS    = 5,
  parameter int unsigned LEVEL_BITS = 6,
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int unsigned COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lmdps_pkg::pix_wr_t            wr_i,
  input  logic [COL_W-1:0]              rd_col_i,
  input  logic [lmdps_pkg::STEP_W-1:0]  step_i,
  output logic [ROWS-1:0]               pattern_o
);

  logic [LEVEL_BITS-1:0] levels_q [ROWS][COLUMNS];
  logic [LEVEL_BITS-1:0] thr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLUMNS; c++) begin
          levels_q[r][c] <= '0;
        end
      end
    end else if (wr_i.en) begin
      levels_q[wr_i.row[ROW_W-1:0]][wr_i.col[COL_W-1:0]] <= LEVEL_BITS'(wr_i.level);
    end
  end

  always_comb begin
    if (step_i < lmdps_pkg::STEP_W'(lmdps_pkg::TABLE_LEN)) begin
      thr = LEVEL_BITS'(lmdps_pkg::DITHER_TABLE[step_i]);
    end else begin
      thr = '1;
    end
  end

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      pattern_o[r] = thr < levels_q[r][rd_col_i];
    end
  end

endmodule

@@ rtl/led_matrix_dithered_pwm_scan_core.sv @@
// Top level of the dithered PWM column scanner for a grayscale LED matrix.
//
// Input beats arrive on the s_axis channel. tuser selects the kind of beat:
// a write beat stores one pixel level in the frame store, and a tick beat
// drives the next column. Writes outside the matrix are dropped, and write
// beats never produce an output beat.
// Each tick beat yields one m_axis beat with the column index and the rows
// lit in it, registered in the output register, or in the skid register on a stall.
// The block accepts one beat per clock cycle while the skid register is empty; the dither
// table compare and the counter updates fit between the input and the output register.
// The step limit is written on the cfg channel, which is always ready. The user must
// write it only while the block is idle; the block itself does not enforce this.
// Reset clears the frame store, the step and column counters, and the valid flags
// of both output registers, and sets the step limit to 40.
// When the receiver stalls, one more tick result is held in a skid register;
// s_axis_tready drops only while that register is full.
module led_matrix_dithered_pwm_scan_core #(
  parameter int unsigned ROWS       = 7,
  parameter int unsigned COLUMNS    = 5,
  parameter int unsigned LEVEL_BITS = 6
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // pixel_row [2:0], pixel_column [5:3], pixel_level [11:6], zero [15:12]
  input  logic [lmdps_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // mode [0]
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // column_index [2:0], row_pattern [9:3], zero [15:10]
  output logic [lmdps_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lmdps_pkg::STEP_W-1:0]       cfg_data_i
);

  localparam int unsigned COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned RES_W = lmdps_pkg::COL_IDX_W + lmdps_pkg::PATTERN_W;

  logic [lmdps_pkg::STEP_W-1:0] limit_q, limit_d;
  logic [lmdps_pkg::STEP_W-1:0] step_q, step_d, step_cur;
  logic [COL_W-1:0]             col_q, col_d, col_cur;
  logic                         out_valid_q, out_valid_d;
  logic                         skid_valid_q, skid_valid_d;
  logic [RES_W-1:0]             out_res_q, out_res_d;
  logic [RES_W-1:0]             skid_res_q, skid_res_d;
  logic [RES_W-1:0]             new_res;
  logic [ROWS-1:0]              pattern;
  logic                         in_fire, tick_fire, m_fire;
  lmdps_pkg::pix_wr_t           pix_wr;

  assign s_axis_tready = !skid_valid_q;
  assign cfg_ready_o   = 1'b1;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign tick_fire     = in_fire && (s_axis_tuser == lmdps_pkg::MODE_TICK);
  assign m_fire        = out_valid_q && m_axis_tready;

  always_comb begin
    pix_wr.row   = s_axis_tdata[2:0];
    pix_wr.col   = s_axis_tdata[5:3];
    pix_wr.level = s_axis_tdata[11:6];
    pix_wr.en    = in_fire && (s_axis_tuser == lmdps_pkg::MODE_WRITE)
                   && ({1'b0, s_axis_tdata[2:0]} < 4'(ROWS))
                   && ({1'b0, s_axis_tdata[5:3]} < 4'(COLUMNS));
  end

  always_comb begin
    step_cur = (step_q > limit_q) ? '0 : step_q;
    col_cur  = ({1'b0, col_q} >= (COL_W + 1)'(COLUMNS)) ? '0 : col_q;
  end

  lmdps_frame #(
    .ROWS       (ROWS),
    .COLUMNS    (COLUMNS),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (pix_wr),
    .rd_col_i  (col_cur),
    .step_i    (step_cur),
    .pattern_o (pattern)
  );

  assign new_res = {lmdps_pkg::PATTERN_W'(pattern), lmdps_pkg::COL_IDX_W'(col_cur)};

  always_comb begin
    limit_d = cfg_valid_i ? cfg_data_i : limit_q;
    step_d  = step_q;
    col_d   = col_q;
    if (tick_fire) begin
      step_d = step_cur + 1'b1;
      col_d  = ({1'b0, col_cur} == (COL_W + 1)'(COLUMNS - 1)) ? '0 : col_cur + 1'b1;
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_res_d    = out_res_q;
    skid_res_d   = skid_res_q;
    if (m_fire) begin
      if (skid_valid_q) begin
        out_res_d    = skid_res_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (tick_fire) begin
      if (!out_valid_q || m_fire) begin
        out_res_d   = new_res;
        out_valid_d = 1'b1;
      end else begin
        skid_res_d   = new_res;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q      <= lmdps_pkg::STEP_LIMIT_RESET;
      step_q       <= '0;
      col_q        <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      limit_q      <= limit_d;
      step_q       <= step_d;
      col_q        <= col_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    skid_res_q <= skid_res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = lmdps_pkg::OUT_DATA_W'(out_res_q);

endmodule

@@ test/led_scan_checker.sv @@
// Checker for the LED matrix scanner: predicts each column drive and compares it.
module led_scan_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [lmdps_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic                            s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [lmdps_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_o,
  input  logic [lmdps_pkg::STEP_W-1:0]    cfg_data_i,
  output int                              pending_o,
  output int                              fail_count_o
);
  import lmdps_pkg::*;

  localparam int MATRIX_ROWS = 7;
  localparam int MATRIX_COLS = 5;
  localparam int DITHER_LEN  = 41;

  localparam logic [5:0] DITHER_STEPS [DITHER_LEN] = '{
    6'd0,  6'd20, 6'd12, 6'd32, 6'd6,  6'd26, 6'd23, 6'd36, 6'd3,  6'd16,
    6'd29, 6'd9,  6'd24, 6'd4,  6'd34, 6'd14, 6'd40, 6'd21, 6'd1,  6'd37,
    6'd7,  6'd11, 6'd31, 6'd7,  6'd27, 6'd35, 6'd15, 6'd25, 6'd5,  6'd30,
    6'd10, 6'd22, 6'd39, 6'd2,  6'd19, 6'd33, 6'd13, 6'd28, 6'd8,  6'd18,
    6'd38
  };

  typedef struct packed {
    logic [2:0] column;
    logic [6:0] rows_lit;
  } column_drive_t;

  logic [5:0]    frame_levels [MATRIX_ROWS][MATRIX_COLS];
  logic [5:0]    pwm_step;
  logic [2:0]    scan_column;
  logic [5:0]    step_limit;
  logic [5:0]    threshold;
  logic [2:0]    wr_row;
  logic [2:0]    wr_col;
  column_drive_t predicted;
  column_drive_t observed;
  column_drive_t oldest;
  column_drive_t expected_drives [$];

  initial fail_count_o = 0;
  initial pending_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MATRIX_ROWS; r++) begin
        for (int c = 0; c < MATRIX_COLS; c++) begin
          frame_levels[r][c] = '0;
        end
      end
      pwm_step = '0;
      scan_column = '0;
      step_limit = 6'd40;
      expected_drives.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        observed.column = m_axis_tdata[2:0];
        observed.rows_lit = m_axis_tdata[9:3];
        if (expected_drives.size() == 0) begin
          $error("output beat with nothing expected, tdata %h", m_axis_tdata);
          fail_count_o = fail_count_o + 1;
        end else begin
          oldest = expected_drives.pop_front();
          if (observed.column !== oldest.column) begin
            $error("column_index: expected %0d, actual %0d", oldest.column, observed.column);
            fail_count_o = fail_count_o + 1;
          end
          if (observed.rows_lit !== oldest.rows_lit) begin
            $error("row_pattern: expected %b, actual %b", oldest.rows_lit,
                   observed.rows_lit);
            fail_count_o = fail_count_o + 1;
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == MODE_TICK) begin
          if (pwm_step > step_limit) begin
            pwm_step = '0;
          end
          threshold = (pwm_step < DITHER_LEN) ? DITHER_STEPS[pwm_step] : 6'h3f;
          predicted.column = scan_column;
          predicted.rows_lit = '0;
          for (int r = 0; r < MATRIX_ROWS; r++) begin
            if (threshold < frame_levels[r][scan_column]) begin
              predicted.rows_lit[r] = 1'b1;
            end
          end
          expected_drives.push_back(predicted);
          pwm_step = pwm_step + 6'd1;
          scan_column = (scan_column == MATRIX_COLS - 1) ? 3'd0 : scan_column + 3'd1;
        end else begin
          wr_row = s_axis_tdata[2:0];
          wr_col = s_axis_tdata[5:3];
          if (wr_row < MATRIX_ROWS && wr_col < MATRIX_COLS) begin
            frame_levels[wr_row][wr_col] = s_axis_tdata[11:6];
          end
        end
      end

      if (cfg_valid_i && cfg_ready_o) begin
        step_limit = cfg_data_i;
      end
      pending_o <= expected_drives.size();
    end
  end

endmodule

@@ test/tb_led_matrix_dithered_pwm_scan_core.sv @@
// Testbench top for the LED matrix scanner: clock, reset, stimulus and verdict.
module tb_led_matrix_dithered_pwm_scan_core;
  import lmdps_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int NUM_PHASES  = 8;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic                   s_axis_tuser = MODE_WRITE;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [STEP_W-1:0]      cfg_data_i = '0;

  int pending;
  int fail_count;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #2 clk_i = ~clk_i;

  led_matrix_dithered_pwm_scan_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  led_scan_checker checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_beat(input logic mode, input logic [2:0] row, input logic [2:0] col,
                           input logic [5:0] level);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {4'b0000, level, col, row};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_step_limit(input logic [STEP_W-1:0] limit);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= limit;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random_beat();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      send_beat(MODE_TICK, 3'($urandom), 3'($urandom), 6'($urandom));
    end else if (pick < 92) begin
      send_beat(MODE_WRITE, 3'($urandom_range(6)), 3'($urandom_range(4)),
                6'($urandom));
    end else begin
      send_beat(MODE_WRITE, 3'($urandom_range(7)), 3'($urandom_range(7, 5)),
                6'($urandom));
    end
  endtask

  initial begin
    logic [STEP_W-1:0] phase_limit [NUM_PHASES];
    int                beat_count;

    phase_limit = '{6'd63, 6'd0, 6'd41, 6'd40, 6'($urandom_range(40)), 6'd7, 6'd63,
                    6'($urandom_range(63))};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extreme levels in the corners and other levels inside the matrix, then writes that fall outside it.
    send_beat(MODE_WRITE, 3'd0, 3'd0, 6'd63);
    send_beat(MODE_WRITE, 3'd6, 3'd4, 6'd63);
    send_beat(MODE_WRITE, 3'd6, 3'd0, 6'd1);
    send_beat(MODE_WRITE, 3'd3, 3'd2, 6'd41);
    send_beat(MODE_WRITE, 3'd0, 3'd4, 6'd0);
    send_beat(MODE_WRITE, 3'd5, 3'd1, 6'd21);
    send_beat(MODE_WRITE, 3'd7, 3'd0, 6'd63);
    send_beat(MODE_WRITE, 3'd0, 3'd5, 6'd63);
    send_beat(MODE_WRITE, 3'd7, 3'd7, 6'd63);
    send_beat(MODE_WRITE, 3'd2, 3'd6, 6'd5);
    // Ticks carry junk in the write fields, which must be ignored.
    send_beat(MODE_TICK, 3'd7, 3'd7, 6'd63);
    send_beat(MODE_TICK, 3'd0, 3'd0, 6'd0);
    repeat (10) begin
      send_beat(MODE_TICK, 3'($urandom), 3'($urandom), 6'($urandom));
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_step_limit(phase_limit[p]);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 85;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 85;
        end
        default: begin
          send_idle_pct = 16;
          recv_stall_pct = 16;
        end
      endcase
      beat_count = (phase_limit[p] == 6'd63) ? 100 : 60;
      repeat (beat_count) send_random_beat();
    end

    recv_stall_pct = 0;
    drain_results();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/lmdps_pkg.sv
rtl/lmdps_frame.sv
rtl/led_matrix_dithered_pwm_scan_core.sv
test/led_scan_checker.sv
test/tb_led_matrix_dithered_pwm_scan_core.sv
